[hdl/ose_pkg.sv]
package ose_pkg;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int WORD_WIDTH_DEF  = 32;

  localparam int MODE_W      = 3;
  localparam int ARG_W       = 10;
  localparam int STATUS_W    = 2;
  localparam int DEPTH_OUT_W = 9;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_EXCH  = 3'd2,
    OP_DUP   = 3'd3,
    OP_COPY  = 3'd4,
    OP_INDEX = 3'd5,
    OP_CLEAR = 3'd6,
    OP_COUNT = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WB,
    S_EXCH
  } state_t;

endpackage

[hdl/ose_ram.sv]
module ose_ram import ose_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int WORD_WIDTH  = WORD_WIDTH_DEF,
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WORD_WIDTH-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [WORD_WIDTH-1:0] rdata
);

  logic [WORD_WIDTH-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/ose_check.sv]
module ose_check import ose_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int DW = $clog2(STACK_DEPTH + 1)
) (
  input  op_t                     mode,
  input  logic signed [ARG_W-1:0] count_arg,
  input  logic [DW-1:0]           depth_cur,
  output status_t                 status
);

  localparam int CW = ((DW > ARG_W) ? DW : ARG_W) + 1;

  logic [CW-1:0] d_ext;
  logic [CW-1:0] n_ext;
  logic [CW-1:0] cap;
  logic          neg;
  logic          full;
  logic          empty;

  assign d_ext = CW'(depth_cur);
  assign n_ext = CW'(count_arg[ARG_W-2:0]);
  assign cap   = CW'(STACK_DEPTH);
  assign neg   = count_arg[ARG_W-1];
  assign full  = (d_ext >= cap);
  assign empty = (d_ext == '0);

  always_comb begin
    status = ST_OK;
    case (mode)
      OP_PUSH, OP_COUNT: begin
        if (full) status = ST_OVER;
      end
      OP_POP: begin
        if (empty) status = ST_UNDER;
      end
      OP_EXCH: begin
        if (d_ext < CW'(2)) status = ST_UNDER;
      end
      OP_DUP: begin
        if (empty) status = ST_UNDER;
        else if (full) status = ST_OVER;
      end
      OP_COPY: begin
        if (neg) status = ST_RANGE;
        else if (n_ext > d_ext) status = ST_UNDER;
        else if (d_ext + n_ext > cap) status = ST_OVER;
      end
      OP_INDEX: begin
        if (neg) status = ST_RANGE;
        else if (n_ext >= d_ext) status = ST_UNDER;
        else if (full) status = ST_OVER;
      end
      default: status = ST_OK;
    endcase
  end

endmodule

[hdl/operand_stack_engine.sv]
// Channel   Handshake            Ports
// command   start, busy          mode, push_word, count_arg
// result    done (one cycle)     status, read_word, depth
//
// A command is taken when start is high and busy is low; its result appears
// on the cycle after the last step with done high for exactly one cycle.
// Push, dup, count, clear, one-entry pop and failed operations end when taken;
// pop and index go through read and write-back states, exch also an exchange
// state, copy a read and a write-back per entry; RAM reads are registered.
// Reset (rst, synchronous) empties the stack; the receiver cannot stall.
module operand_stack_engine import ose_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [MODE_W-1:0]       mode,
  input  logic [WORD_WIDTH-1:0]   push_word,
  input  logic signed [ARG_W-1:0] count_arg,
  output logic                    done,
  output logic [STATUS_W-1:0]     status,
  output logic [WORD_WIDTH-1:0]   read_word,
  output logic [DEPTH_OUT_W-1:0]  depth
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int CW = ((DW > ARG_W) ? DW : ARG_W) + 1;

  state_t                state, state_next;
  logic [DW-1:0]         depth_q, depth_q_next;
  logic [WORD_WIDTH-1:0] top_q, top_q_next;
  logic [AW-1:0]         src, src_next;
  logic [DW-1:0]         remain, remain_next;
  op_t                   op_q, op_q_next;
  status_t               status_q, status_q_next;
  logic                  done_q;

  op_t                   cmd_op;
  status_t               chk_status;
  logic                  accept;
  logic                  go_read;
  logic                  finish;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic [WORD_WIDTH-1:0] mem_rdata;
  logic [CW-1:0]         d_ext;
  logic [CW-1:0]         n_ext;
  logic [AW-1:0]         dpos;
  logic [AW-1:0]         below_top;
  logic [AW-1:0]         second_addr;
  logic [AW-1:0]         index_addr;
  logic [AW-1:0]         copy_addr;
  logic [WORD_WIDTH+DW-1:0]  cnt_ext;
  logic [WORD_WIDTH-1:0]     cnt_word;
  logic [DW+DEPTH_OUT_W-1:0] depth_ext;

  assign cmd_op = op_t'(mode);
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  ose_check #(.STACK_DEPTH(STACK_DEPTH)) u_check (
    .mode      (cmd_op),
    .count_arg (count_arg),
    .depth_cur (depth_q),
    .status    (chk_status)
  );

  ose_ram #(.STACK_DEPTH(STACK_DEPTH), .WORD_WIDTH(WORD_WIDTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (src),
    .rdata (mem_rdata)
  );

  // Address arithmetic is only used once the check has passed, so none of
  // these differences can go negative when it matters.
  assign d_ext       = CW'(depth_q);
  assign n_ext       = CW'(count_arg[ARG_W-2:0]);
  assign dpos        = depth_q[AW-1:0];
  assign below_top   = AW'(d_ext - CW'(1));
  assign second_addr = AW'(d_ext - CW'(2));
  assign index_addr  = AW'(d_ext - CW'(1) - n_ext);
  assign copy_addr   = AW'(d_ext - n_ext);

  assign cnt_ext  = {{WORD_WIDTH{1'b0}}, depth_q};
  assign cnt_word = cnt_ext[WORD_WIDTH-1:0];

  assign go_read = accept && (chk_status == ST_OK) &&
                   ((cmd_op == OP_POP && depth_q != DW'(1)) ||
                    cmd_op == OP_EXCH || cmd_op == OP_INDEX ||
                    (cmd_op == OP_COPY && n_ext != '0));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (go_read) state_next = S_READ;
      end
      S_READ: state_next = S_WB;
      S_WB: begin
        if (op_q == OP_EXCH) state_next = S_EXCH;
        else if (op_q == OP_COPY && remain != DW'(1)) state_next = S_READ;
        else state_next = S_IDLE;
      end
      S_EXCH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = dpos;
    mem_wdata     = top_q;
    finish        = 1'b0;
    depth_q_next  = depth_q;
    top_q_next    = top_q;
    src_next      = src;
    remain_next   = remain;
    op_q_next     = op_q;
    status_q_next = status_q;
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_q_next     = cmd_op;
          status_q_next = chk_status;
          if (chk_status != ST_OK) begin
            finish = 1'b1;
          end else begin
            case (cmd_op)
              OP_PUSH: begin
                mem_we       = 1'b1;
                mem_wdata    = push_word;
                top_q_next   = push_word;
                depth_q_next = depth_q + DW'(1);
                finish       = 1'b1;
              end
              OP_DUP: begin
                mem_we       = 1'b1;
                depth_q_next = depth_q + DW'(1);
                finish       = 1'b1;
              end
              OP_COUNT: begin
                mem_we       = 1'b1;
                mem_wdata    = cnt_word;
                top_q_next   = cnt_word;
                depth_q_next = depth_q + DW'(1);
                finish       = 1'b1;
              end
              OP_CLEAR: begin
                depth_q_next = '0;
                finish       = 1'b1;
              end
              OP_POP: begin
                if (depth_q == DW'(1)) begin
                  depth_q_next = '0;
                  finish       = 1'b1;
                end else begin
                  src_next = second_addr;
                end
              end
              OP_EXCH: src_next = second_addr;
              OP_INDEX: src_next = index_addr;
              OP_COPY: begin
                if (n_ext == '0) begin
                  finish = 1'b1;
                end else begin
                  src_next    = copy_addr;
                  remain_next = n_ext[DW-1:0];
                end
              end
              default: finish = 1'b1;
            endcase
          end
        end
      end
      S_READ: begin
      end
      S_WB: begin
        case (op_q)
          OP_POP: begin
            top_q_next   = mem_rdata;
            depth_q_next = depth_q - DW'(1);
            finish       = 1'b1;
          end
          OP_EXCH: begin
            // The old top goes one slot down; the second entry comes up.
            mem_we     = 1'b1;
            mem_waddr  = src;
            top_q_next = mem_rdata;
          end
          OP_INDEX: begin
            mem_we       = 1'b1;
            mem_wdata    = mem_rdata;
            top_q_next   = mem_rdata;
            depth_q_next = depth_q + DW'(1);
            finish       = 1'b1;
          end
          OP_COPY: begin
            // Sources all lie below the original depth, so the writes above
            // it never disturb an entry still to be read. The top is unchanged.
            mem_we       = 1'b1;
            mem_wdata    = mem_rdata;
            depth_q_next = depth_q + DW'(1);
            src_next     = src + AW'(1);
            remain_next  = remain - DW'(1);
            finish       = (remain == DW'(1));
          end
          default: finish = 1'b1;
        endcase
      end
      S_EXCH: begin
        mem_we    = 1'b1;
        mem_waddr = below_top;
        finish    = 1'b1;
      end
      default: finish = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      depth_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state   <= state_next;
      depth_q <= depth_q_next;
      done_q  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    top_q    <= top_q_next;
    src      <= src_next;
    remain   <= remain_next;
    op_q     <= op_q_next;
    status_q <= status_q_next;
  end

  assign depth_ext = {{DEPTH_OUT_W{1'b0}}, depth_q};

  assign done      = done_q;
  assign status    = status_q;
  assign read_word = (depth_q == '0) ? '0 : top_q;
  assign depth     = depth_ext[DEPTH_OUT_W-1:0];

endmodule

[hdl/ose_checker.sv]
module ose_port_checks import ose_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic [MODE_W-1:0]       mode,
  input logic [WORD_WIDTH-1:0]   push_word,
  input logic                    done,
  input logic [STATUS_W-1:0]     status,
  input logic [WORD_WIDTH-1:0]   read_word,
  input logic [DEPTH_OUT_W-1:0]  depth
);

  // A result is only shown once the engine has gone back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Every accepted transaction either finishes at once or keeps the engine busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transaction neither busy nor done");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == OP_CLEAR) |=>
      (done && status == ST_OK && depth == '0 && read_word == '0))
    else $error("clear did not empty the stack");

  a_push_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == OP_PUSH) |=>
      (done && (status == ST_OVER || read_word == $past(push_word))))
    else $error("push result does not show the pushed word");

endmodule

bind operand_stack_engine ose_port_checks #(.WORD_WIDTH(WORD_WIDTH)) u_ose_port_checks (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .mode      (mode),
  .push_word (push_word),
  .done      (done),
  .status    (status),
  .read_word (read_word),
  .depth     (depth)
);
